@@ rtl/dng_pkg.sv @@
`timescale 1ns / 1ps

package dng_pkg;

	localparam int AbsW  = 22;
	localparam int YearW = 14;
	localparam int MonW  = 4;
	localparam int DayW  = 5;

	localparam int Days400 = 146097;
	localparam int Days100 = 36524;
	localparam int Days4   = 1461;
	localparam int Days1   = 365;

	localparam int Years400 = 400;
	localparam int Years100 = 100;
	localparam int Years4   = 4;

	// reciprocal estimates: floor(x * R >> K) is the quotient or one less
	localparam int Div400Shift = 32;
	localparam longint Recip400 = (longint'(1) << Div400Shift) / Days400;
	localparam int Recip400W = $clog2(Recip400 + 1);
	localparam int Div4Shift = 26;
	localparam longint Recip4 = (longint'(1) << Div4Shift) / Days4;
	localparam int Recip4W = $clog2(Recip4 + 1);

	localparam int C400W = 5;   // up to 28 over the full field
	localparam int Rem400W = 18;
	localparam int C100W = 3;   // 0..4
	localparam int Rem100W = 16;
	localparam int C4W = 5;     // 0..24
	localparam int Rem4W = 11;
	localparam int C1W = 3;     // 0..4
	localparam int DoyW = 9;

	localparam int LastCent = 4;
	localparam int LastYear = 4;
	localparam int LeapYearIdx = 3;
	localparam int LastQuad = 24;
	localparam int QuadCent = 3;

	localparam logic [MonW-1:0] MonthDec = MonW'(12);
	localparam logic [DayW-1:0] DayDecLast = DayW'(31);

	typedef struct packed {
		logic [C400W-1:0]   c400;
		logic [Rem400W-1:0] rem;
	} div400_t;

	typedef struct packed {
		logic [YearW-1:0] ycnt;
		logic [C100W-1:0] c100;
		logic [C4W-1:0]   c4;
		logic [C1W-1:0]   c1;
		logic [DoyW-1:0]  day0;
	} split_t;

	// common-year days through the end of month m (m = 0..11)
	typedef logic [DoyW-1:0] cum_arr_t [12];
	localparam cum_arr_t CumDays = '{
		9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
		9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
	};

	function automatic logic [DoyW-1:0] cum_days(input logic leap, input logic [MonW-1:0] m);
		logic [DoyW-1:0] v;
		v = (m < MonW'(12)) ? CumDays[m] : CumDays[11];
		if (leap && m >= MonW'(2))
			v = v + DoyW'(1);
		return v;
	endfunction

endpackage

@@ rtl/day_number_to_gregorian.sv @@
// Pipeline: the 400-year split (dng_div400), then the century/4-year/year split
// (dng_split), then the month search (dng_month).
// Throughput: one item per cycle; a stalled result holds the whole pipeline.
// Reset: arst_n clears all valid bits at once; the data registers are not reset.
`timescale 1ns / 1ps

module day_number_to_gregorian (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [dng_pkg::AbsW-1:0]  abs_day,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [dng_pkg::YearW-1:0] year_out,
	output logic [dng_pkg::MonW-1:0]  month_out,
	output logic [dng_pkg::DayW-1:0]  day_out
);

	logic              en;
	logic              d4_vld, sp_vld;
	dng_pkg::div400_t  d4_data;
	dng_pkg::split_t   sp_data;

	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	dng_div400 u_div400 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (in_valid),
		.abs_day  (abs_day),
		.out_vld  (d4_vld),
		.out_data (d4_data)
	);

	dng_split u_split (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (d4_vld),
		.in_data  (d4_data),
		.out_vld  (sp_vld),
		.out_data (sp_data)
	);

	dng_month u_month (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_vld    (sp_vld),
		.in_data   (sp_data),
		.out_vld   (out_valid),
		.year_out  (year_out),
		.month_out (month_out),
		.day_out   (day_out)
	);

	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (month_out >= dng_pkg::MonW'(1) && month_out <= dng_pkg::MonW'(12)))
		else $error("month out of range");

	a_day_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (day_out != '0 && year_out != '0))
		else $error("zero day or year");

	a_feb_len: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && month_out == dng_pkg::MonW'(2)) |-> (day_out <= dng_pkg::DayW'(29)))
		else $error("February too long");

	a_short_month: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (month_out == dng_pkg::MonW'(4) || month_out == dng_pkg::MonW'(6) ||
		 month_out == dng_pkg::MonW'(9) || month_out == dng_pkg::MonW'(11)))
		|-> (day_out <= dng_pkg::DayW'(30)))
		else $error("30-day month overrun");

endmodule

@@ rtl/dng_div400.sv @@
`timescale 1ns / 1ps

module dng_div400 (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_vld,
	input  logic [dng_pkg::AbsW-1:0]    abs_day,
	output logic                        out_vld,
	output dng_pkg::div400_t            out_data
);

	localparam int ProdW = dng_pkg::AbsW + dng_pkg::Recip400W;

	logic                         vld_s1, vld_s2, vld_s3;
	logic [dng_pkg::AbsW-1:0]     rest_s1, rest_s2;
	logic [dng_pkg::C400W-1:0]    est_s2;
	dng_pkg::div400_t             res_s3;

	logic [ProdW-1:0]             prod;
	logic [dng_pkg::AbsW-1:0]     diff;
	dng_pkg::div400_t             res;

	assign prod = ProdW'(rest_s1) * ProdW'(dng_pkg::Recip400);

	always_comb begin
		diff = rest_s2 - dng_pkg::AbsW'(est_s2 * dng_pkg::Days400);
		if (diff >= dng_pkg::AbsW'(dng_pkg::Days400)) begin
			res.c400 = est_s2 + dng_pkg::C400W'(1);
			res.rem  = dng_pkg::Rem400W'(diff - dng_pkg::AbsW'(dng_pkg::Days400));
		end else begin
			res.c400 = est_s2;
			res.rem  = dng_pkg::Rem400W'(diff);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// day zero is folded onto day one
			rest_s1 <= (abs_day == '0) ? '0 : abs_day - dng_pkg::AbsW'(1);
			rest_s2 <= rest_s1;
			est_s2  <= prod[dng_pkg::Div400Shift +: dng_pkg::C400W];
			res_s3  <= res;
		end
	end

	assign out_vld  = vld_s3;
	assign out_data = res_s3;

endmodule

@@ rtl/dng_split.sv @@
`timescale 1ns / 1ps

module dng_split (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  dng_pkg::div400_t  in_data,
	output logic              out_vld,
	output dng_pkg::split_t   out_data
);

	localparam int ProdW = dng_pkg::Rem100W + dng_pkg::Recip4W;

	logic                          vld_s1, vld_s2, vld_s3, vld_s4;
	logic [dng_pkg::C100W-1:0]     c100_s1, c100_s2, c100_s3;
	logic [dng_pkg::Rem100W-1:0]   rem100_s1, rem100_s2;
	logic [dng_pkg::YearW-1:0]     ybase_s1, ybase_s2, ybase_s3;
	logic [dng_pkg::C4W-1:0]       est4_s2, c4_s3;
	logic [dng_pkg::Rem4W-1:0]     rem4_s3;
	dng_pkg::split_t               res_s4;

	logic [dng_pkg::C100W-1:0]     c100;
	logic [ProdW-1:0]              prod;
	logic [dng_pkg::Rem100W-1:0]   diff4;
	logic [dng_pkg::C4W-1:0]       c4;
	logic [dng_pkg::Rem4W-1:0]     rem4;
	logic [dng_pkg::C1W-1:0]       c1;
	dng_pkg::split_t               res;

	// centuries within the 400-year cycle: threshold compares
	always_comb begin
		c100 = '0;
		for (int k = 1; k <= dng_pkg::LastCent; k++)
			if (in_data.rem >= dng_pkg::Rem400W'(k * dng_pkg::Days100))
				c100 = c100 + dng_pkg::C100W'(1);
	end

	assign prod = ProdW'(rem100_s1) * ProdW'(dng_pkg::Recip4);

	always_comb begin
		diff4 = rem100_s2 - dng_pkg::Rem100W'(est4_s2 * dng_pkg::Days4);
		if (diff4 >= dng_pkg::Rem100W'(dng_pkg::Days4)) begin
			c4   = est4_s2 + dng_pkg::C4W'(1);
			rem4 = dng_pkg::Rem4W'(diff4 - dng_pkg::Rem100W'(dng_pkg::Days4));
		end else begin
			c4   = est4_s2;
			rem4 = dng_pkg::Rem4W'(diff4);
		end
	end

	always_comb begin
		c1 = '0;
		for (int k = 1; k <= dng_pkg::LastYear; k++)
			if (rem4_s3 >= dng_pkg::Rem4W'(k * dng_pkg::Days1))
				c1 = c1 + dng_pkg::C1W'(1);
		res.c100 = c100_s3;
		res.c4   = c4_s3;
		res.c1   = c1;
		res.day0 = dng_pkg::DoyW'(rem4_s3 - dng_pkg::Rem4W'(c1 * dng_pkg::Days1));
		res.ycnt = ybase_s3 + dng_pkg::YearW'(c1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c100_s1   <= c100;
			rem100_s1 <= dng_pkg::Rem100W'(in_data.rem -
				dng_pkg::Rem400W'(c100 * dng_pkg::Days100));
			ybase_s1  <= dng_pkg::YearW'(in_data.c400 * dng_pkg::Years400) +
				dng_pkg::YearW'(c100 * dng_pkg::Years100);

			c100_s2   <= c100_s1;
			rem100_s2 <= rem100_s1;
			ybase_s2  <= ybase_s1;
			est4_s2   <= prod[dng_pkg::Div4Shift +: dng_pkg::C4W];

			c100_s3   <= c100_s2;
			c4_s3     <= c4;
			rem4_s3   <= rem4;
			ybase_s3  <= ybase_s2 + dng_pkg::YearW'(c4 * dng_pkg::Years4);

			res_s4    <= res;
		end
	end

	assign out_vld  = vld_s4;
	assign out_data = res_s4;

endmodule

@@ rtl/dng_month.sv @@
`timescale 1ns / 1ps

module dng_month (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_vld,
	input  dng_pkg::split_t           in_data,
	output logic                      out_vld,
	output logic [dng_pkg::YearW-1:0] year_out,
	output logic [dng_pkg::MonW-1:0]  month_out,
	output logic [dng_pkg::DayW-1:0]  day_out
);

	logic                        vld_s1, vld_s2;
	logic                        dec_s1, leap_s1;
	logic [dng_pkg::YearW-1:0]   year_s1, year_s2;
	logic [dng_pkg::DoyW-1:0]    doy_s1;
	logic [dng_pkg::MonW-1:0]    mon_s1, mon_s2;
	logic [dng_pkg::DayW-1:0]    day_s2;

	logic                        dec, leap;
	logic [dng_pkg::DoyW-1:0]    doy;
	logic [dng_pkg::MonW-1:0]    mon;

	always_comb begin
		// last day of a leap cycle lands on 31 December of the counted year
		dec  = (in_data.c100 == dng_pkg::C100W'(dng_pkg::LastCent)) ||
			(in_data.c1 == dng_pkg::C1W'(dng_pkg::LastYear));
		// next year is divisible by 4; not by 100 unless also by 400
		leap = (in_data.c1 == dng_pkg::C1W'(dng_pkg::LeapYearIdx)) &&
			((in_data.c4 != dng_pkg::C4W'(dng_pkg::LastQuad)) ||
			 (in_data.c100 == dng_pkg::C100W'(dng_pkg::QuadCent)));
		doy  = in_data.day0 + dng_pkg::DoyW'(1);
		mon  = dng_pkg::MonW'(1);
		for (int m = 1; m < 12; m++)
			if (doy > dng_pkg::cum_days(leap, dng_pkg::MonW'(m)))
				mon = mon + dng_pkg::MonW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dec_s1  <= dec;
			leap_s1 <= leap;
			year_s1 <= dec ? in_data.ycnt : in_data.ycnt + dng_pkg::YearW'(1);
			doy_s1  <= doy;
			mon_s1  <= mon;

			year_s2 <= year_s1;
			mon_s2  <= dec_s1 ? dng_pkg::MonthDec : mon_s1;
			day_s2  <= dec_s1 ? dng_pkg::DayDecLast :
				dng_pkg::DayW'(doy_s1 - dng_pkg::cum_days(leap_s1, mon_s1 - dng_pkg::MonW'(1)));
		end
	end

	assign out_vld   = vld_s2;
	assign year_out  = year_s2;
	assign month_out = mon_s2;
	assign day_out   = day_s2;

endmodule

@@ tb/sv/tb_day_number_to_gregorian.sv @@
`timescale 1ns / 1ps

module tb_day_number_to_gregorian;

	localparam int PipeDepth  = 9;
	localparam int RandItems  = 1150;
	localparam int HoldCycles = 200;
	localparam int IdleLimit  = 4000;
	localparam int MaxReports = 10;
	localparam int LastDay    = 3652059;      // 31 Dec 9999
	localparam int FieldMax   = (1 << dng_pkg::AbsW) - 1;

	typedef struct packed {
		logic [dng_pkg::YearW-1:0] year;
		logic [dng_pkg::MonW-1:0]  month;
		logic [dng_pkg::DayW-1:0]  day;
	} greg_date_t;

	typedef struct packed {
		logic [dng_pkg::AbsW-1:0] abs;
		greg_date_t               date;
	} due_date_t;

	class date_board;
		due_date_t due_dates[$];
		int        errors;
		int        days_in;
		int        dates_out;
		int        past_range;
		int        leap_days;
		int        cycle_ends;

		function greg_date_t date_of_day(logic [dng_pkg::AbsW-1:0] n);
			int unsigned r, q400, q100, q4, q1, yr, mo, dy;
			bit          leap;
			int unsigned mlen[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
			greg_date_t  g;
			r = (n == '0) ? 0 : n - 1;    // no day zero: treated as day 1
			q400 = r / dng_pkg::Days400;
			r    = r % dng_pkg::Days400;
			q100 = r / dng_pkg::Days100;
			r    = r % dng_pkg::Days100;
			q4   = r / dng_pkg::Days4;
			r    = r % dng_pkg::Days4;
			q1   = r / dng_pkg::Days1;
			dy   = r % dng_pkg::Days1 + 1;
			yr   = 400 * q400 + 100 * q100 + 4 * q4 + q1;
			if (q100 == 4 || q1 == 4) begin
				// last day of a leap cycle
				mo = 12;
				dy = 31;
				cycle_ends++;
			end else begin
				yr++;
				leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
				if (leap)
					mlen[1] = 29;
				mo = 1;
				while (mo < 12 && dy > mlen[mo - 1]) begin
					dy -= mlen[mo - 1];
					mo++;
				end
			end
			g.year  = yr[dng_pkg::YearW-1:0];
			g.month = mo[dng_pkg::MonW-1:0];
			g.day   = dy[dng_pkg::DayW-1:0];
			return g;
		endfunction

		function void note_day(logic [dng_pkg::AbsW-1:0] n);
			due_date_t e;
			e.abs  = n;
			e.date = date_of_day(n);
			due_dates.push_back(e);
			days_in++;
			if (n > LastDay)
				past_range++;
			if (e.date.month == dng_pkg::MonW'(2) && e.date.day == dng_pkg::DayW'(29))
				leap_days++;
		endfunction

		function void check_date(logic [dng_pkg::YearW-1:0] y, logic [dng_pkg::MonW-1:0] m,
			logic [dng_pkg::DayW-1:0] d);
			due_date_t e;
			dates_out++;
			if (due_dates.size() == 0) begin
				errors++;
				if (errors <= MaxReports)
					$display("%0t: unexpected result %0d-%0d-%0d", $time, y, m, d);
				return;
			end
			e = due_dates.pop_front();
			if (e.date.year !== y || e.date.month !== m || e.date.day !== d) begin
				errors++;
				if (errors <= MaxReports)
					$display("%0t: day %0d: expected %0d-%0d-%0d, got %0d-%0d-%0d", $time,
						e.abs, e.date.year, e.date.month, e.date.day, y, m, d);
			end
		endfunction

		function int pending();
			return due_dates.size();
		endfunction
	endclass

	logic                        clk;
	logic                        arst_n;
	logic                        in_valid;
	logic                        in_stall;
	logic [dng_pkg::AbsW-1:0]    abs_day;
	logic                        out_valid;
	logic                        out_stall;
	logic [dng_pkg::YearW-1:0]   year_out;
	logic [dng_pkg::MonW-1:0]    month_out;
	logic [dng_pkg::DayW-1:0]    day_out;

	date_board sb = new();
	bit        hold_req;

	day_number_to_gregorian u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.abs_day   (abs_day),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.year_out  (year_out),
		.month_out (month_out),
		.day_out   (day_out)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// called just after a rising edge; returns at the edge that takes the item
	task automatic send_day(input logic [dng_pkg::AbsW-1:0] n);
		in_valid <= 1'b1;
		abs_day  <= n;
		do @(posedge clk); while (in_stall);
		sb.note_day(n);
	endtask

	task automatic wait_drained();
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	function automatic logic [dng_pkg::AbsW-1:0] pick_day();
		int sel, unit, v;
		sel = $urandom_range(99);
		if (sel < 60)
			return dng_pkg::AbsW'($urandom_range(LastDay, 1));
		if (sel < 75)
			return dng_pkg::AbsW'($urandom_range(FieldMax, 0));
		// near the edge of a 400-, 100-, 4- or 1-year cycle
		case ($urandom_range(3))
			0:       unit = dng_pkg::Days400;
			1:       unit = dng_pkg::Days100;
			2:       unit = dng_pkg::Days4;
			default: unit = dng_pkg::Days1;
		endcase
		v = unit * $urandom_range(FieldMax / unit) + $urandom_range(4) - 2;
		if (v < 0)
			v = 0;
		if (v > FieldMax)
			v = FieldMax;
		return dng_pkg::AbsW'(v);
	endfunction

	// receiver: stall phases of random density, plus a long hold-off on request
	initial begin
		int phase_left, stall_pct, hold_left;
		bit hold_done;
		phase_left = 0;
		stall_pct  = 0;
		hold_left  = 0;
		hold_done  = 1'b0;
		out_stall  = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				sb.check_date(year_out, month_out, day_out);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HoldCycles;
			end
			if (phase_left == 0) begin
				phase_left = $urandom_range(80, 5);
				case ($urandom_range(4))
					0, 1:    stall_pct = 0;
					2:       stall_pct = 30;
					3:       stall_pct = 60;
					default: stall_pct = 90;
				endcase
			end
			phase_left--;
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// watchdog: ends the run when nothing moves for too long
	initial begin
		int idle;
		idle = 0;
		while (idle < IdleLimit) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle = 0;
			else
				idle++;
		end
		$display("%0t: no item moved for %0d cycles", $time, IdleLimit);
		$display("[day_number_to_gregorian] ERROR");
		$finish;
	end

	initial begin
		logic [dng_pkg::AbsW-1:0] directed[$];
		int                       i, burst;
		bit                       mid_drain;
		directed = '{
			dng_pkg::AbsW'(0), dng_pkg::AbsW'(1), dng_pkg::AbsW'(2), dng_pkg::AbsW'(31),
			dng_pkg::AbsW'(32), dng_pkg::AbsW'(59), dng_pkg::AbsW'(60),
			dng_pkg::AbsW'(365), dng_pkg::AbsW'(366), dng_pkg::AbsW'(1155),
			dng_pkg::AbsW'(1460), dng_pkg::AbsW'(1461), dng_pkg::AbsW'(1462),
			dng_pkg::AbsW'(36524), dng_pkg::AbsW'(146096), dng_pkg::AbsW'(146097),
			dng_pkg::AbsW'(146098), dng_pkg::AbsW'(730179),
			dng_pkg::AbsW'(LastDay), dng_pkg::AbsW'(LastDay + 1),
			dng_pkg::AbsW'(22'h155555), dng_pkg::AbsW'(22'h2AAAAA),
			dng_pkg::AbsW'(22'h200000), dng_pkg::AbsW'(FieldMax - 1),
			dng_pkg::AbsW'(FieldMax)
		};
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		abs_day   = '0;
		hold_req  = 1'b0;
		mid_drain = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[k])
			send_day(directed[k]);
		in_valid <= 1'b0;
		wait_drained();

		i = 0;
		while (i < RandItems) begin
			burst = $urandom_range(30, 1);
			while (burst > 0 && i < RandItems) begin
				if (i == 350)
					hold_req = 1'b1;
				send_day(pick_day());
				burst--;
				i++;
			end
			if ($urandom_range(3) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(12, 1)) @(posedge clk);
			end
			if (i >= 800 && !mid_drain) begin
				// sender goes quiet until every result is back
				in_valid <= 1'b0;
				wait_drained();
				mid_drain = 1'b1;
			end
		end
		in_valid <= 1'b0;
		wait_drained();
		repeat (PipeDepth + 4) @(posedge clk);

		$display("Converted %0d day numbers to %0d dates: %0d past year 9999, %0d leap days,",
			sb.days_in, sb.dates_out, sb.past_range, sb.leap_days);
		$display("%0d last days of leap cycles; %0d mismatches", sb.cycle_ends, sb.errors);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("[day_number_to_gregorian] OK");
		else
			$display("[day_number_to_gregorian] ERROR");
		$finish;
	end

endmodule

@@ files.f @@
rtl/dng_pkg.sv
rtl/dng_div400.sv
rtl/dng_split.sv
rtl/dng_month.sv
rtl/day_number_to_gregorian.sv
tb/sv/tb_day_number_to_gregorian.sv
